[design/tlvp_pkg.sv]
// Shared types and constants of the TLV record parser.
package tlvp_pkg;

   localparam logic [7:0] IMAGE_REC_CODE  = 8'h02;
   localparam int         HDR_LEN_BYTES   = 4;
   localparam int         IMG_HDR_BYTES   = 8;
   localparam int         RSP_DEPTH_DFLT  = 8;

   localparam logic       KIND_RECORD     = 1'b0;
   localparam logic       KIND_SUMMARY    = 1'b1;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_TRUNC_HDR    = 3'd1;
   localparam logic [2:0] ST_TRUNC_PAY    = 3'd2;
   localparam logic [2:0] ST_IMG_SHORT    = 3'd3;
   localparam logic [2:0] ST_PIX_OVER     = 3'd4;

   typedef struct packed {
      logic        kind;
      logic [7:0]  rtype;
      logic [31:0] rlen;
      logic [39:0] rsum;
      logic [2:0]  status;
      logic [31:0] count;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic         first_valid;
      logic         second_valid;
      rsp_word_type first;
      rsp_word_type second;
   } rsp_push_type;

endpackage

[design/tlvp_parse.sv]
// Record parser state and per-byte next-state and result logic.
module tlvp_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  logic [7:0]            item_byte,
   input  logic                  item_eos,
   output tlvp_pkg::rsp_push_type push
);
   import tlvp_pkg::*;

   localparam logic [1:0] PH_TYPE    = 2'd0;
   localparam logic [1:0] PH_LEN     = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_SKIP    = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  hidx_ff, hidx_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] off_ff, off_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [39:0] sum_ff, sum_in;
   logic [31:0] good_ff, good_in;
   logic [2:0]  err_ff, err_in;
   logic [55:0] prod_ff, prod_in;

   logic        fin;
   logic        fail_req;
   logic [2:0]  fail_code;
   logic        rec_valid;
   logic [2:0]  rec_status;
   logic [39:0] rec_sum;
   logic [1:0]  phase_mid;
   logic [31:0] good_mid;
   logic [2:0]  err_mid;
   logic [39:0] wb;
   logic [63:0] pixels;
   logic [31:0] room_base;
   logic [31:0] kidx;
   rsp_word_type rec_w, sum_w;

   always_comb begin
      phase_in  = phase_ff;
      hidx_in   = hidx_ff;
      type_in   = type_ff;
      len_in    = len_ff;
      off_in    = off_ff;
      width_in  = width_ff;
      height_in = height_ff;
      sum_in    = sum_ff;
      err_in    = err_ff;
      prod_in   = prod_ff;
      fin       = 1'b0;
      fail_req  = 1'b0;
      fail_code = ST_OK;
      wb        = width_ff * {32'd0, item_byte};
      pixels    = {8'd0, prod_ff} + {wb, 24'd0};
      room_base = len_ff - 32'(IMG_HDR_BYTES);
      kidx      = off_ff - 32'(IMG_HDR_BYTES);
      case (phase_ff)
         PH_TYPE: begin
            type_in   = item_byte;
            len_in    = '0;
            off_in    = '0;
            hidx_in   = '0;
            width_in  = '0;
            height_in = '0;
            sum_in    = '0;
            phase_in  = PH_LEN;
            if (item_eos) begin
               fail_req  = 1'b1;
               fail_code = ST_TRUNC_HDR;
            end
         end
         PH_LEN: begin
            len_in  = len_ff | ({24'd0, item_byte} << {hidx_ff, 3'b000});
            hidx_in = hidx_ff + 2'd1;
            if (hidx_ff == 2'(HDR_LEN_BYTES - 1)) begin
               if (len_in == '0) begin
                  fin = 1'b1;
               end else begin
                  phase_in = PH_PAYLOAD;
                  if (item_eos) begin
                     fail_req  = 1'b1;
                     fail_code = ST_TRUNC_PAY;
                  end
               end
            end else if (item_eos) begin
               fail_req  = 1'b1;
               fail_code = ST_TRUNC_HDR;
            end
         end
         PH_PAYLOAD: begin
            if (type_ff == IMAGE_REC_CODE) begin
               if (off_ff[31:2] == '0) begin
                  width_in = width_ff | ({24'd0, item_byte} << {off_ff[1:0], 3'b000});
               end else if (off_ff[31:3] == '0) begin
                  height_in = height_ff | ({24'd0, item_byte} << {off_ff[1:0], 3'b000});
                  // height low 24 bits complete: partial product ahead of the top byte
                  if (off_ff[2:0] == 3'd6) begin
                     prod_in = width_ff * {32'd0, height_in[23:0]};
                  end
                  if (off_ff[2:0] == 3'd7) begin
                     if (pixels > {34'd0, room_base[31:2]}) begin
                        err_in = ST_PIX_OVER;
                     end
                  end
               end else if (err_ff == ST_OK && height_ff != '0) begin
                  if (kidx[1:0] == 2'd0 && kidx[31:2] < width_ff) begin
                     sum_in = sum_ff + {32'd0, item_byte};
                  end
               end
            end
            off_in = off_ff + 32'd1;
            if (off_in == len_ff) begin
               fin = 1'b1;
            end else if (item_eos) begin
               fail_req  = 1'b1;
               fail_code = ST_TRUNC_PAY;
            end
         end
         default: begin
         end
      endcase

      if (fin) begin
         if (type_in == IMAGE_REC_CODE && len_in < 32'(IMG_HDR_BYTES)) begin
            fail_req  = 1'b1;
            fail_code = ST_IMG_SHORT;
         end else if (err_in != ST_OK) begin
            fail_req  = 1'b1;
            fail_code = err_in;
         end
      end

      rec_valid  = 1'b0;
      rec_status = ST_OK;
      rec_sum    = '0;
      phase_mid  = phase_in;
      good_mid   = good_ff;
      err_mid    = err_in;
      if (fail_req) begin
         rec_valid  = 1'b1;
         rec_status = fail_code;
         err_mid    = fail_code;
         phase_mid  = PH_SKIP;
      end else if (fin) begin
         rec_valid = 1'b1;
         if (good_ff != '1) begin
            good_mid = good_ff + 32'd1;
         end
         rec_sum   = (type_in == IMAGE_REC_CODE) ? sum_in : '0;
         phase_mid = PH_TYPE;
      end

      rec_w.kind   = KIND_RECORD;
      rec_w.rtype  = type_in;
      rec_w.rlen   = len_in;
      rec_w.rsum   = rec_sum;
      rec_w.status = rec_status;
      rec_w.count  = good_mid;
      rec_w.last   = !item_eos;

      sum_w.kind   = KIND_SUMMARY;
      sum_w.rtype  = '0;
      sum_w.rlen   = '0;
      sum_w.rsum   = '0;
      sum_w.status = err_mid;
      sum_w.count  = good_mid;
      sum_w.last   = 1'b1;

      good_in  = good_mid;
      err_in   = err_mid;
      phase_in = phase_mid;
      if (item_eos) begin
         phase_in = PH_TYPE;
         good_in  = '0;
         err_in   = ST_OK;
      end

      push.first_valid  = item_valid && (rec_valid || item_eos);
      push.second_valid = item_valid && rec_valid && item_eos;
      push.first        = rec_valid ? rec_w : sum_w;
      push.second       = sum_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TYPE;
         hidx_ff   <= '0;
         type_ff   <= '0;
         len_ff    <= '0;
         off_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         sum_ff    <= '0;
         good_ff   <= '0;
         err_ff    <= ST_OK;
      end else if (item_valid) begin
         phase_ff  <= phase_in;
         hidx_ff   <= hidx_in;
         type_ff   <= type_in;
         len_ff    <= len_in;
         off_ff    <= off_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         sum_ff    <= sum_in;
         good_ff   <= good_in;
         err_ff    <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid) begin
         prod_ff <= prod_in;
      end
   end

   a_eos_restarts: assert property (@(posedge clock) disable iff (reset)
      (item_valid && item_eos) |=> (phase_ff == PH_TYPE && good_ff == '0 && err_ff == ST_OK))
      else $error("stream end did not restart parser");

   a_count_monotone: assert property (@(posedge clock) disable iff (reset)
      (item_valid && !item_eos) |=> (good_ff >= $past(good_ff)))
      else $error("record count went down inside a stream");

   a_skip_has_error: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP) |-> (err_ff != ST_OK))
      else $error("skipping without an error code");

endmodule

[design/tlvp_rsp_fifo.sv]
// Result queue: takes up to two words per cycle, delivers one.
module tlvp_rsp_fifo #(
   parameter int DEPTH = tlvp_pkg::RSP_DEPTH_DFLT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tlvp_pkg::rsp_push_type        push,
   input  logic                          pop,
   output tlvp_pkg::rsp_word_type        head,
   output logic                          head_valid,
   output logic [$clog2(DEPTH+1)-1:0]    count
);
   import tlvp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   rsp_word_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]       head_ff, head_in;
   logic [PTR_W-1:0]       tail_ff, tail_in;
   logic [PTR_W-1:0]       tail_p1;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      do_pop   = pop && (count_ff != '0);
      tail_p1  = ptr_inc(tail_ff);
      head_in  = do_pop ? ptr_inc(head_ff) : head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push.first_valid) begin
         tail_in = push.second_valid ? ptr_inc(tail_p1) : tail_p1;
      end
      count_in = count_ff + CNT_W'(push.first_valid) + CNT_W'(push.second_valid)
                 - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         mem_ff[tail_ff] <= push.first;
      end
      if (push.second_valid) begin
         mem_ff[tail_p1] <= push.second;
      end
   end

   assign head       = mem_ff[head_ff];
   assign head_valid = (count_ff != '0);
   assign count      = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (({1'b0, count_ff} + (CNT_W+1)'(push.first_valid) + (CNT_W+1)'(push.second_valid))
       <= (CNT_W+1)'(DEPTH)))
      else $error("result queue overflow");

   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      push.second_valid |-> push.first_valid)
      else $error("second word pushed alone");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (count_ff == '0 && head_ff == tail_ff))
      else $error("queue not empty after reset");

endmodule

[design/tlv_record_parser_core.sv]
// Top level of the TLV record parser: input stage, parser and result queue.
//
//  channel | dir | handshake           | word
//  req     | in  | req_tvalid/tready   | tdata: data_byte; tlast: end_of_stream
//  rsp     | out | rsp_tvalid/tready   | tdata: record fields; tuser: kind; tlast: last
//
// One byte per cycle while req_tready is high: a byte is registered, parsed in
// the next cycle and its zero, one or two result words are written to the result
// queue at the end of that cycle; rsp_tvalid comes from the registered queue count.
// A byte that ends the stream yields two words unless the parser is skipping after
// an error; the queue drains one word per cycle if rsp_tready is high; req_tready
// drops only when the queue cannot hold two more words beyond those in flight.
// Reset is synchronous and clears parser state and the queue.
module tlv_record_parser_core #(
   parameter int RSP_DEPTH = tlvp_pkg::RSP_DEPTH_DFLT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // end_of_stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [7:0] record_type, [39:8] record_length, [79:40] row_sum,
   // [82:80] status, [114:83] record_count, [119:115] zero
   output logic [119:0] rsp_tdata,
   output logic         rsp_tuser,   // result_kind
   output logic         rsp_tlast    // last
);
   import tlvp_pkg::*;

   localparam int CNT_W = $clog2(RSP_DEPTH+1);

   logic             stage_valid_ff, stage_valid_in;
   logic [7:0]       stage_byte_ff;
   logic             stage_eos_ff;
   logic             req_take;
   logic [CNT_W-1:0] q_count;
   logic             q_valid;
   rsp_push_type     push;
   rsp_word_type     head;

   assign req_tready = ({1'b0, q_count} + (CNT_W+1)'(stage_valid_ff ? 2 : 0))
                       <= (CNT_W+1)'(RSP_DEPTH - 2);
   assign req_take       = req_tvalid && req_tready;
   assign stage_valid_in = req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_byte_ff <= req_tdata;
         stage_eos_ff  <= req_tlast;
      end
   end

   tlvp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .item_valid (stage_valid_ff),
      .item_byte  (stage_byte_ff),
      .item_eos   (stage_eos_ff),
      .push       (push)
   );

   tlvp_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_tready),
      .head       (head),
      .head_valid (q_valid),
      .count      (q_count)
   );

   assign rsp_tvalid = q_valid;
   assign rsp_tdata  = {5'd0, head.count, head.status, head.rsum, head.rlen, head.rtype};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

endmodule
